// ===== rtl/core/msi_pkg.sv =====
// Shared types and constants for the merge-insertion sorter core.
// No dependencies; imported by msi_cell and merge_insertion_sorter_core.
package msi_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 31;

    typedef logic [VALUE_W-1:0] t_value;

    typedef struct packed {
        t_value value;
        logic   final_item;
    } t_in;

    typedef struct packed {
        t_value sorted_value;
        logic   last_result;
        logic   items_dropped;
    } t_out;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic   insert;     // place ctl value into the sorted chain
        logic   shift_out;  // move every entry one cell toward the head
        t_value value;      // value being inserted
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

// ===== rtl/core/msi_cell.sv =====
// One cell of the systolic insertion chain: holds one entry and its valid bit.
// Depends on msi_pkg.
module msi_cell
    import msi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_value    i_prev_value,
    input  logic      i_prev_valid,
    input  logic      i_prev_gt,
    input  t_value    i_next_value,
    input  logic      i_next_valid,
    output t_value    o_value,
    output logic      o_valid,
    output logic      o_gt
);

    t_value r_value;
    t_value n_value;
    logic   r_valid;
    logic   n_valid;

    // Entry is strictly greater than the incoming value: it moves up one cell.
    assign o_gt = r_valid && (r_value > i_ctl.value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.insert) begin
            if (i_prev_gt) begin
                n_value = i_prev_value;
            end else if (o_gt || (!r_valid && i_prev_valid)) begin
                n_value = i_ctl.value;
            end
            n_valid = r_valid | i_prev_valid;
        end else if (i_ctl.shift_out) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// ===== rtl/core/merge_insertion_sorter_core.sv =====
// Sorter core: a chain of MAX_ITEMS insertion cells plus drain control.
// Depends on msi_pkg and msi_cell.
// Fill: one value per cycle (start high, busy low); every cell compares it at once
// and it is registered in sorted position, or dropped with the loss flag if full.
// Drain: after the final item the chain shifts toward cell 0, one result per
// cycle through the state and result registers; busy while the chain drains.
// Reset (synchronous, active low) empties the chain and clears the loss flag.
module merge_insertion_sorter_core
    import msi_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_in,
    output logic o_busy,
    output logic o_strobe,
    output t_out o_result
);

    t_state    r_state;
    t_state    n_state;
    logic      r_overflow;
    logic      r_strobe;
    t_out      r_result;
    t_cell_ctl ctl;
    logic      accept;
    logic      full;

    t_value cell_value [MAX_ITEMS];
    logic   cell_valid [MAX_ITEMS];
    logic   cell_gt    [MAX_ITEMS];
    t_value prev_value [MAX_ITEMS];
    logic   prev_valid [MAX_ITEMS];
    logic   prev_gt    [MAX_ITEMS];
    t_value next_value [MAX_ITEMS];
    logic   next_valid [MAX_ITEMS];

    assign o_busy = (r_state == ST_DRAIN);
    assign accept = i_start && !o_busy;
    // Chain fills from cell 0 upward, so the top cell marks a full store.
    assign full   = cell_valid[MAX_ITEMS-1];

    always_comb begin
        ctl.insert    = accept && !full;
        ctl.shift_out = (r_state == ST_DRAIN);
        ctl.value     = i_in.value;
    end

    // Neighbor wiring; the chain ends act as an always-occupied slot below
    // cell 0 and an empty slot above the top cell.
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_chain
        if (g == 0) begin : g_head
            assign prev_value[g] = '0;
            assign prev_valid[g] = 1'b1;
            assign prev_gt[g]    = 1'b0;
        end else begin : g_mid
            assign prev_value[g] = cell_value[g-1];
            assign prev_valid[g] = cell_valid[g-1];
            assign prev_gt[g]    = cell_gt[g-1];
        end
        if (g == MAX_ITEMS - 1) begin : g_tail
            assign next_value[g] = '0;
            assign next_valid[g] = 1'b0;
        end else begin : g_body
            assign next_value[g] = cell_value[g+1];
            assign next_valid[g] = cell_valid[g+1];
        end

        msi_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_prev_value (prev_value[g]),
            .i_prev_valid (prev_valid[g]),
            .i_prev_gt    (prev_gt[g]),
            .i_next_value (next_value[g]),
            .i_next_valid (next_valid[g]),
            .o_value      (cell_value[g]),
            .o_valid      (cell_valid[g]),
            .o_gt         (cell_gt[g])
        );
    end

    // Drain ends when cell 0 holds the last entry (nothing above it).
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (accept && i_in.final_item) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!next_valid[0]) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_overflow <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_DRAIN);
            if (accept && full) begin
                r_overflow <= 1'b1;
            end else if ((r_state == ST_DRAIN) && !next_valid[0]) begin
                r_overflow <= 1'b0;
            end
        end
    end

    // Result register: the head cell is presented while the chain shifts.
    always_ff @(posedge i_clk) begin
        r_result.sorted_value  <= cell_value[0];
        r_result.last_result   <= !next_valid[0];
        r_result.items_dropped <= r_overflow;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
